// ===== rtl/core/dtid_pkg.sv =====
// Package with the types, codes and constants of the DER TLV header and integer decoder.
`default_nettype none

package dtid_pkg;

  localparam int unsigned MaxLengthBytes = 4;
  localparam int unsigned ValueBytes     = 4;

  localparam logic [7:0] TagReset  = 8'd2;
  localparam logic [7:0] ByteAllOn = 8'hFF;

  typedef enum logic [1:0] {
    PH_TAG       = 2'd0,
    PH_LEN_FIRST = 2'd1,
    PH_LEN_LONG  = 2'd2,
    PH_CONTENT   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_TAG  = 2'd1,
    ST_LEN  = 2'd2,
    ST_DATA = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_INT    = 2'd1,
    MODE_BOOL   = 2'd2,
    MODE_NULL   = 2'd3
  } mode_e;

  typedef enum logic [7:0] {
    CFG_EXPECTED_TAG = 8'd0,
    CFG_DECODE_MODE  = 8'd1
  } cfg_index_e;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  len_bytes_pend;
    logic [31:0] len_acc;
    logic [31:0] avail_cnt;
    logic [31:0] content_pend;
    logic [30:0] value_acc;
    logic [2:0]  sig_bytes;
    logic        first_content;
  } dtid_state_t;

  typedef struct packed {
    logic        emit;
    status_e     status;
    logic [31:0] content_length;
    logic [30:0] decoded_value;
  } dtid_result_t;

  localparam dtid_state_t StateReset = '{
    phase:          PH_TAG,
    len_bytes_pend: 3'd0,
    len_acc:        32'd0,
    avail_cnt:      32'd0,
    content_pend:   32'd0,
    value_acc:      31'd0,
    sig_bytes:      3'd0,
    first_content:  1'b1
  };

endpackage

`default_nettype wire

// ===== rtl/core/dtid_step.sv =====
// Per-byte decode step: next decoder state and the result an item causes.
`default_nettype none

module dtid_step (
  input  dtid_pkg::dtid_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic [31:0]            bytes_left_i,
  input  logic [7:0]             expected_tag_i,
  input  dtid_pkg::mode_e        decode_mode_i,
  output dtid_pkg::dtid_state_t  state_o,
  output dtid_pkg::dtid_result_t result_o
);
  import dtid_pkg::*;

  logic        hdr_fold;
  status_e     hdr_data_code;
  logic        hd_go;
  logic [31:0] hd_len;
  logic [31:0] hd_avail;
  logic [31:0] avail_dec;
  logic [6:0]  len_count;
  logic [31:0] pend_dec;
  logic [38:0] value_shift;

  // Boolean and null modes fold every header fault into invalid length.
  assign hdr_fold      = (decode_mode_i inside {MODE_BOOL, MODE_NULL});
  assign hdr_data_code = hdr_fold ? ST_LEN : ST_DATA;
  assign avail_dec     = state_i.avail_cnt - 32'd1;
  assign len_count     = data_byte_i[6:0];
  assign pend_dec      = (state_i.content_pend != 32'd0) ?
                         state_i.content_pend - 32'd1 : state_i.content_pend;
  assign value_shift   = {state_i.value_acc, data_byte_i};

  always_comb begin
    state_o  = state_i;
    result_o = '{emit: 1'b0, status: ST_OK, content_length: 32'd0, decoded_value: 31'd0};
    hd_go    = 1'b0;
    hd_len   = 32'd0;
    hd_avail = 32'd0;

    case (state_i.phase)
      PH_TAG: begin
        if (bytes_left_i == 32'd0 || data_byte_i != expected_tag_i) begin
          result_o.emit   = 1'b1;
          result_o.status = hdr_fold ? ST_LEN : ST_TAG;
        end else begin
          state_o.avail_cnt = bytes_left_i - 32'd1;
          state_o.len_acc   = 32'd0;
          state_o.phase     = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        state_o.avail_cnt = avail_dec;
        if (state_i.avail_cnt == 32'd0) begin
          result_o.emit   = 1'b1;
          result_o.status = hdr_data_code;
        end else if (!data_byte_i[7]) begin
          state_o.len_acc = {24'd0, data_byte_i};
          hd_go    = 1'b1;
          hd_len   = {24'd0, data_byte_i};
          hd_avail = avail_dec;
        end else if (len_count == 7'd0 || len_count > 7'(MaxLengthBytes)) begin
          result_o.emit   = 1'b1;
          result_o.status = ST_LEN;
        end else if (avail_dec < {25'd0, len_count}) begin
          result_o.emit   = 1'b1;
          result_o.status = hdr_data_code;
        end else begin
          state_o.len_bytes_pend = len_count[2:0];
          state_o.len_acc        = 32'd0;
          state_o.phase          = PH_LEN_LONG;
        end
      end
      PH_LEN_LONG: begin
        if (state_i.avail_cnt != 32'd0) begin
          state_o.avail_cnt = avail_dec;
        end
        state_o.len_acc = {state_i.len_acc[23:0], data_byte_i};
        if (state_i.len_bytes_pend != 3'd0) begin
          state_o.len_bytes_pend = state_i.len_bytes_pend - 3'd1;
        end
        if (state_i.len_bytes_pend <= 3'd1) begin
          hd_go    = 1'b1;
          hd_len   = state_o.len_acc;
          hd_avail = state_o.avail_cnt;
        end
      end
      PH_CONTENT: begin
        result_o.content_length = state_i.len_acc;
        if (decode_mode_i == MODE_BOOL) begin
          result_o.emit          = 1'b1;
          result_o.decoded_value = {30'd0, data_byte_i == ByteAllOn};
        end else begin
          state_o.content_pend  = pend_dec;
          state_o.first_content = 1'b0;
          if (state_i.first_content && data_byte_i[7]) begin
            result_o.emit   = 1'b1;
            result_o.status = ST_LEN;
          end else begin
            if (state_i.sig_bytes != 3'd0 || data_byte_i != 8'd0) begin
              if (state_i.sig_bytes < 3'd7) begin
                state_o.sig_bytes = state_i.sig_bytes + 3'd1;
              end
              state_o.value_acc = value_shift[30:0];
              // A new leading byte must leave room for the bytes behind it.
              if (state_i.sig_bytes == 3'd0 &&
                  (pend_dec > 32'(ValueBytes - 1) ||
                   (pend_dec == 32'(ValueBytes - 1) && data_byte_i[7]))) begin
                result_o.emit   = 1'b1;
                result_o.status = ST_LEN;
              end else if (value_shift[38:31] != 8'd0) begin
                result_o.emit   = 1'b1;
                result_o.status = ST_LEN;
              end
            end
            if (!result_o.emit && pend_dec == 32'd0) begin
              result_o.emit          = 1'b1;
              result_o.decoded_value = state_o.value_acc;
            end
          end
        end
      end
      default: begin
        state_o = StateReset;
      end
    endcase

    if (hd_go) begin
      result_o.content_length = hd_len;
      if (hd_len > hd_avail) begin
        result_o.emit   = 1'b1;
        result_o.status = hdr_data_code;
      end else begin
        case (decode_mode_i)
          MODE_HEADER: begin
            result_o.emit = 1'b1;
          end
          MODE_INT: begin
            if (hd_len == 32'd0) begin
              result_o.emit   = 1'b1;
              result_o.status = ST_LEN;
            end
          end
          MODE_BOOL: begin
            if (hd_len != 32'd1) begin
              result_o.emit   = 1'b1;
              result_o.status = ST_LEN;
            end
          end
          default: begin
            result_o.emit = 1'b1;
            if (hd_len != 32'd0) begin
              result_o.status = ST_LEN;
            end
          end
        endcase
        if (!result_o.emit) begin
          state_o.phase         = PH_CONTENT;
          state_o.content_pend  = hd_len;
          state_o.first_content = 1'b1;
          state_o.sig_bytes     = 3'd0;
          state_o.value_acc     = 31'd0;
        end
      end
    end

    // Every result ends the element, so the decoder waits for a new tag.
    if (result_o.emit) begin
      state_o = StateReset;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/der_tlv_header_integer_decoder.sv =====
// Top level of the DER TLV header and integer decoder.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+------------------------------------------
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in_valid_i/in_ready_o   | data_byte_i, bytes_left_i
//   out     | out_valid_o/out_ready_i | status_o, content_length_o, decoded_value_o
//
// One stream byte is taken per cycle; its result, if any, appears in the output
// register on the next cycle. The byte decode is a single combinational step
// between the decoder state registers and the output register.
// The input stalls only while a result sits in the output register and is not taken.
// Reset returns to waiting for a tag byte with expected tag 2 and integer mode.
// Configuration writes are always taken and act on the next byte.
`default_nettype none

module der_tlv_header_integer_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] bytes_left_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] content_length_o,
  output logic [30:0] decoded_value_o
);
  import dtid_pkg::*;

  logic         in_accept;
  logic [7:0]   expected_tag_q;
  mode_e        decode_mode_q;
  dtid_state_t  state_q, state_d;
  dtid_result_t step_res;
  logic         out_valid_q, out_valid_d;
  status_e      status_q;
  logic [31:0]  content_length_q;
  logic [30:0]  decoded_value_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;

  dtid_step u_step (
    .state_i        (state_q),
    .data_byte_i    (data_byte_i),
    .bytes_left_i   (bytes_left_i),
    .expected_tag_i (expected_tag_q),
    .decode_mode_i  (decode_mode_q),
    .state_o        (state_d),
    .result_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_tag_q <= TagReset;
      decode_mode_q  <= MODE_INT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EXPECTED_TAG: expected_tag_q <= cfg_data_i;
        CFG_DECODE_MODE:  decode_mode_q  <= mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && step_res.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && step_res.emit) begin
      status_q         <= step_res.status;
      content_length_q <= step_res.content_length;
      decoded_value_q  <= step_res.decoded_value;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign content_length_o = content_length_q;
  assign decoded_value_o  = decoded_value_q;

  // The input side only waits on a result that is still held.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input stalled without a held result");

  // A result always sends the decoder back to the tag byte.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && step_res.emit) |=> (state_q.phase == PH_TAG && state_q.first_content))
    else $error("decoder did not restart after a result");

  // Error results never carry a value.
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> (decoded_value_q == 31'd0))
    else $error("error result carries a value");

  // Long-form length bytes are only counted within the supported range.
  a_len_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_LEN_LONG) |->
      (state_q.len_bytes_pend != 3'd0 && state_q.len_bytes_pend <= 3'(MaxLengthBytes)))
    else $error("long-form length count out of range");

endmodule

`default_nettype wire
